FILE: sv/mgrt_pkg.sv
`timescale 1ns / 1ps
package mgrt_pkg;

  localparam int VAL_W = 32;
  localparam int CAP_W = 11;
  localparam int CNT_OUT_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_REPORT
  } mgrt_state_t;

  typedef struct packed {
    logic start;
    logic room;
    logic cnt_zero;
    logic scan_last;
    logic pipe_busy;
  } mgrt_sts_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic reject;
    logic scan;
    logic update;
    logic report;
  } mgrt_ctl_t;

endpackage

FILE: sv/mgrt_store.sv
`timescale 1ns / 1ps
module mgrt_store #(
  parameter int DEPTH = 1024,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/mgrt_absdiff.sv
`timescale 1ns / 1ps
module mgrt_absdiff (
  input  logic signed [mgrt_pkg::VAL_W-1:0] a,
  input  logic signed [mgrt_pkg::VAL_W-1:0] b,
  output logic        [mgrt_pkg::VAL_W-1:0] diff
);

  import mgrt_pkg::*;

  logic signed [VAL_W:0] d;
  logic        [VAL_W:0] mag;

  // full width difference, never overflows
  always_comb begin
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    mag = d[VAL_W] ? (~d + (VAL_W+1)'(1)) : d;
    diff = mag[VAL_W-1:0];
  end

endmodule

FILE: sv/mgrt_ctrl.sv
`timescale 1ns / 1ps
module mgrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  mgrt_pkg::mgrt_sts_t sts,
  output mgrt_pkg::mgrt_ctl_t ctl
);

  import mgrt_pkg::*;

  mgrt_state_t state_r;
  mgrt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.start) begin
          priority if (!sts.room) begin
            state_nxt = ST_REPORT;
          end else if (sts.cnt_zero) begin
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.load = sts.start;
        ctl.reject = sts.start && !sts.room;
      end
      ST_SCAN: begin
        ctl.busy = 1'b1;
        ctl.scan = 1'b1;
      end
      ST_DRAIN: begin
        ctl.busy = 1'b1;
      end
      ST_UPDATE: begin
        ctl.busy = 1'b1;
        ctl.update = 1'b1;
      end
      ST_REPORT: begin
        ctl.busy = 1'b1;
        ctl.report = 1'b1;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: sv/min_gap_and_range_tracker_top.sv
`timescale 1ns / 1ps
// an accepted word goes from idle to report if rejected, to update then report
//   if it is the first word, else to scan, drain, update and report; a new word
//   is taken only when busy is low; the scan reads one held value per cycle from
//   the single read port of the value store, so cycles grow with the count
// synchronous active-low reset clears count, spans, capacity and the sequencer
// out_valid is a one-cycle strobe; the receiver cannot stall
module min_gap_and_range_tracker_top #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mgrt_pkg::VAL_W-1:0] in_new_value,
  input  logic                              cfg_wr_en,
  input  logic [mgrt_pkg::CAP_W-1:0]        cfg_wr_data,
  output logic                              out_valid,
  output logic                              out_status,
  output logic [mgrt_pkg::CNT_OUT_W-1:0]    out_held_count,
  output logic                              out_spans_valid,
  output logic [mgrt_pkg::VAL_W-1:0]        out_shortest_gap,
  output logic [mgrt_pkg::VAL_W-1:0]        out_longest_range
);

  import mgrt_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  mgrt_sts_t sts;
  mgrt_ctl_t ctl;

  logic [CAP_W-1:0]        capacity_r;
  logic [CNT_W-1:0]        count_r;
  logic [ADDR_W-1:0]       idx_r;
  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] smallest_r;
  logic signed [VAL_W-1:0] largest_r;
  logic [VAL_W-1:0]        best_r;
  logic [VAL_W-1:0]        diff_r;
  logic                    rd_vld_r;
  logic                    diff_vld_r;

  logic                    out_valid_r;
  logic                    out_status_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic                    out_spans_r;
  logic [VAL_W-1:0]        out_gap_r;
  logic [VAL_W-1:0]        out_range_r;

  logic                    status_r;
  logic [VAL_W-1:0]        rd_data;
  logic signed [VAL_W-1:0] op_a;
  logic signed [VAL_W-1:0] op_b;
  logic [VAL_W-1:0]        unit_diff;
  logic                    room;
  logic                    spans;

  assign room = (CMP_W'(count_r) < CMP_W'(capacity_r)) &&
                (CMP_W'(count_r) < CMP_W'(STORE_DEPTH));
  assign spans = (count_r >= CNT_W'(2));

  always_comb begin
    sts.start = start;
    sts.room = room;
    sts.cnt_zero = (count_r == '0);
    sts.scan_last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
    sts.pipe_busy = rd_vld_r || diff_vld_r;
  end

  mgrt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .ctl  (ctl)
  );

  mgrt_store #(
    .DEPTH (STORE_DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(VAL_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (ctl.update),
    .wr_addr(count_r[ADDR_W-1:0]),
    .wr_data(value_r),
    .rd_en  (ctl.scan),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  // shared difference unit: scan compares, then the report span
  assign op_a = ctl.report ? largest_r : value_r;
  assign op_b = ctl.report ? smallest_r : $signed(rd_data);

  mgrt_absdiff u_absdiff (
    .a   (op_a),
    .b   (op_b),
    .diff(unit_diff)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= in_new_value;
    end
    if (rd_vld_r) begin
      diff_r <= unit_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctl.load) begin
      idx_r <= '0;
    end else if (ctl.scan) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      diff_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.scan;
      diff_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
    end else if (ctl.load) begin
      status_r <= ctl.reject;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '1;
    end else if (diff_vld_r && (diff_r < best_r)) begin
      best_r <= diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      smallest_r <= '0;
      largest_r <= '0;
    end else if (ctl.update) begin
      count_r <= count_r + CNT_W'(1);
      if (count_r == '0) begin
        smallest_r <= value_r;
        largest_r <= value_r;
      end else begin
        if (value_r < smallest_r) begin
          smallest_r <= value_r;
        end
        if (value_r > largest_r) begin
          largest_r <= value_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      out_status_r <= status_r;
      out_count_r <= CNT_OUT_W'(count_r);
      out_spans_r <= spans;
      out_gap_r <= spans ? best_r : '0;
      out_range_r <= spans ? unit_diff : '0;
    end
  end

  assign busy = ctl.busy;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_held_count = out_count_r;
  assign out_spans_valid = out_spans_r;
  assign out_shortest_gap = out_gap_r;
  assign out_longest_range = out_range_r;

  a_strobe_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.report |=> out_valid && !busy)
    else $error("result strobe missing after report");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(STORE_DEPTH))
    else $error("held count above store depth");

  a_pipe_empty_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.update |-> !rd_vld_r && !diff_vld_r)
    else $error("store updated while compares in flight");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.reject |=> $stable(count_r) && $stable(best_r))
    else $error("rejected word changed state");

endmodule
